@@ rtl/edd_pkg.sv @@
// ----------------------------------------------------------------------------
// edd_pkg
// Shared types, constants and helpers of the error diffusion dither core.
// ----------------------------------------------------------------------------
package edd_pkg;

  localparam int MAX_LINE_WIDTH = 4096;
  localparam int SAMPLE_BITS    = 16;
  localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
  localparam int ERR_W          = 24;
  localparam int X_W            = 26;   // working value: sample*16 + two errors
  localparam int LUM_W          = 33;
  localparam int NUM_W          = 50;
  localparam int QV_W           = 21;
  localparam int DIV_NW         = 52;   // dividend and quotient width
  localparam int DIV_DW         = 28;   // divisor width
  localparam int DIV_CW         = $clog2(DIV_NW + 1);
  localparam int MEM_W          = 3 * ERR_W;

  // level search: power-of-two shift, fold by 2^SAMPLE_BITS - 1, then /25 in gray
  localparam int FOLD_W         = 47;
  localparam int FQ_W           = 32;
  localparam int FOLD_STEPS     = 4;
  localparam int LVL_SH_RGB     = 5;    // 2*unit   = 32 * (2^16 - 1)
  localparam int LVL_SH_GRAY    = 7;    // 200*unit = 128 * 25 * (2^16 - 1)
  localparam int GRAY_W         = 21;   // folded quotient width fed to the /25
  localparam int RCP_W          = 43;
  localparam int RCP_SHIFT      = 26;

  localparam logic [QV_W-1:0] SAMPLE_MAX = QV_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [QV_W-1:0] UNIT       = QV_W'(16 * ((1 << SAMPLE_BITS) - 1));

  localparam logic [DIV_NW-1:0] DEN_RGB  = DIV_NW'(16 * ((1 << SAMPLE_BITS) - 1));
  localparam logic [DIV_NW-1:0] DEN_GRAY = DIV_NW'(1600 * ((1 << SAMPLE_BITS) - 1));
  localparam logic [FQ_W-1:0]   GRAY_FOLD_MAX = FQ_W'(25 << SAMPLE_BITS);
  localparam logic [21:0]       RCP_25 = 22'd2684355;   // ceil(2^26 / 25)

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MODE         = 2'd0,
    REG_LEVELS       = 2'd1,
    REG_LINE_WIDTH   = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_LUM, ST_MUL,
    ST_LVL_GO, ST_LVL_WAIT, ST_QV_GO, ST_QV_WAIT, ST_OV_GO, ST_OV_WAIT,
    ST_ERR, ST_WR1, ST_WR2, ST_OUT
  } state_t;

  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic        end_of_frame;
  } pixel_out_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [27:0] v);
    logic signed [27:0] hi;
    logic signed [27:0] lo;
    hi = 28'sd8388607;
    lo = -28'sd8388608;
    if (v > hi) return ERR_W'(hi);
    if (v < lo) return ERR_W'(lo);
    return ERR_W'(v);
  endfunction

  // floor(e*k/16); never leaves 24 bits for k up to 7
  function automatic logic signed [ERR_W-1:0] share16(input logic signed [ERR_W-1:0] e,
                                                     input logic [2:0] k);
    logic signed [27:0] p;
    p = 28'(e) * $signed({25'b0, k});
    return ERR_W'(p >>> 4);
  endfunction

endpackage

@@ rtl/edd_line_mem.sv @@
// ----------------------------------------------------------------------------
// edd_line_mem
// Line store of errors for the next row, one word of three channels a column.
// ----------------------------------------------------------------------------
module edd_line_mem import edd_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [COL_W-1:0] waddr,
  input  logic [MEM_W-1:0] wdata,
  input  logic [COL_W-1:0] raddr,
  output logic [MEM_W-1:0] rdata
);

  logic [MEM_W-1:0] mem [MAX_LINE_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/edd_div.sv @@
// ----------------------------------------------------------------------------
// edd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module edd_div import edd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  output logic              done,
  output logic [DIV_NW-1:0] quotient
);

  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] divisor;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic [DIV_DW:0]   trial;
  logic              ge;

  assign trial = {rem, quotient[DIV_NW-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= '0;
      quotient <= req.dividend;
      divisor  <= req.divisor;
    end else if (busy) begin
      rem      <= ge ? DIV_DW'(trial - {1'b0, divisor}) : DIV_DW'(trial);
      quotient <= {quotient[DIV_NW-2:0], ge};
    end
  end

endmodule

@@ rtl/error_diffusion_dither_core.sv @@
// ----------------------------------------------------------------------------
// error_diffusion_dither_core
// Floyd-Steinberg dither of a raster RGB stream to a set number of levels.
// ----------------------------------------------------------------------------
//  channel | signals                                  | role
//  --------+------------------------------------------+---------------------
//  src     | src_valid, src_stall, src_pixel          | input pixel item
//  dst     | dst_valid, dst_stall, dst_pixel          | dithered pixel item
//  apb     | psel, penable, pwrite, paddr, pwdata ... | register access
//
//  Each item passes from one accept to the next possible accept through two
//  rounds of the 52-bit serial dividers (error reference value, output value);
//  the level takes a shift-and-fold search instead of a divider round.
//  Items are handled one at a time; the next item is taken as soon as the
//  previous result sits in the output register, even while it is stalled.
//  Reset (rst, synchronous) restores register defaults and clears position,
//  carry and pending errors; the line store needs no clearing since row 0
//  never reads it.
// ----------------------------------------------------------------------------
module error_diffusion_dither_core import edd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  pixel_in_t   src_pixel,
  output logic        dst_valid,
  input  logic        dst_stall,
  output pixel_out_t  dst_pixel,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---- configuration registers ---------------------------------------------
  logic        mode;
  logic [16:0] levels;
  logic [12:0] line_width;
  logic [15:0] frame_height;
  reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b1;
      levels       <= 17'd256;
      line_width   <= 13'd4096;
      frame_height <= 16'd1080;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_MODE:         mode         <= pwdata[0];
        REG_LEVELS:       levels       <= pwdata[16:0];
        REG_LINE_WIDTH:   line_width   <= pwdata[12:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:         prdata = {31'b0, mode};
      REG_LEVELS:       prdata = {15'b0, levels};
      REG_LINE_WIDTH:   prdata = {19'b0, line_width};
      REG_FRAME_HEIGHT: prdata = {16'b0, frame_height};
    endcase
  end

  // ---- clamped geometry and level count --------------------------------------
  logic [COL_W-1:0] w_last;
  logic [15:0]      h_last;
  logic [15:0]      f_lvl;     // levels - 1

  always_comb begin
    if (line_width < 13'd2)                         w_last = COL_W'(1);
    else if (line_width > 13'(MAX_LINE_WIDTH))      w_last = COL_W'(MAX_LINE_WIDTH - 1);
    else                                            w_last = COL_W'(line_width - 13'd1);
    h_last = (frame_height == 16'd0) ? 16'd0 : frame_height - 16'd1;
    if (levels < 17'd2)           f_lvl = 16'd1;
    else if (levels >= 17'd65536) f_lvl = 16'd65535;
    else                          f_lvl = levels[15:0] - 16'd1;
  end

  // ---- frame position --------------------------------------------------------
  logic [COL_W-1:0] column_count;
  logic [15:0]      row_count;
  logic [COL_W-1:0] col_now;
  logic [COL_W-1:0] col;
  logic             last_col;
  logic             row_zero;

  assign col_now = (column_count > w_last) ? w_last : column_count;

  // ---- state machine ---------------------------------------------------------
  state_t state;
  state_t state_next;
  logic   take;
  logic   out_free;
  logic   div_done;
  logic   lvl_done;

  assign take      = src_valid && !src_stall;
  assign src_stall = (state != ST_IDLE);
  assign out_free  = !dst_valid || !dst_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (src_valid) state_next = ST_READ;
      ST_READ:     state_next = ST_LUM;
      ST_LUM:      state_next = ST_MUL;
      ST_MUL:      state_next = ST_LVL_GO;
      ST_LVL_GO:   state_next = ST_LVL_WAIT;
      ST_LVL_WAIT: if (lvl_done) state_next = ST_QV_GO;
      ST_QV_GO:    state_next = ST_QV_WAIT;
      ST_QV_WAIT:  if (div_done) state_next = ST_OV_GO;
      ST_OV_GO:    state_next = ST_OV_WAIT;
      ST_OV_WAIT:  if (div_done) state_next = ST_ERR;
      ST_ERR:      state_next = ST_WR1;
      ST_WR1:      state_next = ST_WR2;
      ST_WR2:      state_next = ST_OUT;
      ST_OUT:      if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // ---- datapath registers ----------------------------------------------------
  logic [15:0]             smp   [3];
  logic signed [X_W-1:0]   xv    [3];
  logic signed [LUM_W-1:0] lum;
  logic signed [NUM_W-1:0] num   [3];
  logic [15:0]             lvl   [3];
  logic [QV_W-1:0]         qv    [3];
  logic [15:0]             ov    [3];
  logic signed [ERR_W-1:0] err   [3];
  logic signed [ERR_W-1:0] carry [3];
  logic signed [ERR_W-1:0] pa    [3];
  logic signed [ERR_W-1:0] pb    [3];

  // level search: fold remainder, folded quotient, step count
  logic [DIV_NW-1:0]       lvl_num  [3];
  logic [FOLD_W-1:0]       fm       [3];
  logic [FQ_W-1:0]         fq       [3];
  logic [2:0]              fcnt;
  logic [RCP_W-1:0]        rcp      [3];
  logic [15:0]             lvl_pick [3];

  logic [MEM_W-1:0]        mem_rdata;
  logic                    mem_we;
  logic [COL_W-1:0]        mem_waddr;
  logic [MEM_W-1:0]        mem_wdata;

  div_req_t                dreq [3];
  logic [DIV_NW-1:0]       quo  [3];
  logic [2:0]              ddone;

  assign div_done = &ddone;
  assign lvl_done = (fcnt == 3'(FOLD_STEPS + 1));

  // ---- level pick --------------------------------------------------------------
  // Round half down: floor((2*num + den - 1) / (2*den)). The divisor 2*den is
  // a power of two times 2^16-1 (times 25 in gray), so shift, fold by 2^16-1,
  // and finish gray with a reciprocal multiply once the quotient is in range.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lvl_num[c] = (num[c] > 0)
          ? DIV_NW'({num[c], 1'b0}) + (mode ? DEN_RGB : DEN_GRAY) - DIV_NW'(1)
          : '0;
      rcp[c] = RCP_W'(fq[c][GRAY_W-1:0]) * RCP_W'(RCP_25);
      if (num[c] <= 0)                                         lvl_pick[c] = '0;
      else if (mode && fq[c] > FQ_W'(f_lvl))                   lvl_pick[c] = f_lvl;
      else if (mode)                                           lvl_pick[c] = fq[c][15:0];
      else if (fq[c] >= GRAY_FOLD_MAX)                         lvl_pick[c] = f_lvl;
      else if (rcp[c][RCP_W-1:RCP_SHIFT] > {1'b0, f_lvl})      lvl_pick[c] = f_lvl;
      else                                  lvl_pick[c] = rcp[c][RCP_SHIFT+15:RCP_SHIFT];
    end
  end

  // ---- output decode: divider requests and line store writes -----------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = col;
    mem_wdata = '0;
    for (int c = 0; c < 3; c++) begin
      dreq[c] = '0;
    end
    unique case (state)
      ST_QV_GO: begin
        for (int c = 0; c < 3; c++) begin
          dreq[c].start    = 1'b1;
          dreq[c].divisor  = DIV_DW'({f_lvl, 1'b0});
          dreq[c].dividend = DIV_NW'(lvl[c]) * DIV_NW'({UNIT, 1'b0}) + DIV_NW'(f_lvl);
        end
      end
      ST_OV_GO: begin
        for (int c = 0; c < 3; c++) begin
          dreq[c].start    = 1'b1;
          dreq[c].divisor  = DIV_DW'({f_lvl, 1'b0});
          dreq[c].dividend = DIV_NW'(lvl[c]) * DIV_NW'({SAMPLE_MAX, 1'b0})
                           + DIV_NW'(f_lvl);
        end
      end
      ST_WR1: begin
        // below-left share joins the pending sum of the previous column
        mem_we    = (col != '0);
        mem_waddr = col - 1'b1;
        for (int c = 0; c < 3; c++) begin
          mem_wdata[c*ERR_W +: ERR_W] = sat_err(28'(pa[c]) + 28'(share16(err[c], 3'd3)));
        end
      end
      ST_WR2: begin
        // row end: flush the pending sum of this column
        mem_we    = last_col;
        mem_waddr = col;
        for (int c = 0; c < 3; c++) begin
          mem_wdata[c*ERR_W +: ERR_W] = pa[c];
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  edd_line_mem u_line (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (col_now),
    .rdata (mem_rdata)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    edd_div u_div (
      .clk      (clk),
      .rst      (rst),
      .req      (dreq[g]),
      .done     (ddone[g]),
      .quotient (quo[g])
    );
  end

  // ---- payload datapath ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (take) begin
      smp[0]   <= src_pixel.red_in;
      smp[1]   <= src_pixel.green_in;
      smp[2]   <= src_pixel.blue_in;
      col      <= col_now;
      last_col <= (col_now == w_last);
      row_zero <= (row_count == 16'd0);
    end
    unique case (state)
      ST_READ: begin
        // sample plus carried error plus error from the row above
        for (int c = 0; c < 3; c++) begin
          xv[c] <= X_W'({smp[c], 4'b0}) + X_W'(carry[c])
                 + (row_zero ? '0 : X_W'($signed(mem_rdata[c*ERR_W +: ERR_W])));
        end
      end
      ST_LUM: begin
        lum <= LUM_W'(xv[0]) * 33'sd30 + LUM_W'(xv[1]) * 33'sd59
             + LUM_W'(xv[2]) * 33'sd11;
      end
      ST_MUL: begin
        for (int c = 0; c < 3; c++) begin
          num[c] <= (mode ? NUM_W'(xv[c]) : NUM_W'(lum)) * $signed({34'b0, f_lvl});
        end
      end
      ST_LVL_GO: begin
        // drop the power-of-two part of the divisor
        fcnt <= '0;
        for (int c = 0; c < 3; c++) begin
          fm[c] <= mode ? FOLD_W'(lvl_num[c] >> LVL_SH_RGB)
                        : FOLD_W'(lvl_num[c] >> LVL_SH_GRAY);
          fq[c] <= '0;
        end
      end
      ST_LVL_WAIT: begin
        // fold the high part down, fix the all-ones remainder, then clamp
        fcnt <= fcnt + 3'd1;
        for (int c = 0; c < 3; c++) begin
          if (fcnt < 3'(FOLD_STEPS)) begin
            fq[c] <= fq[c] + FQ_W'(fm[c][FOLD_W-1:SAMPLE_BITS]);
            fm[c] <= FOLD_W'(fm[c][FOLD_W-1:SAMPLE_BITS])
                   + FOLD_W'(fm[c][SAMPLE_BITS-1:0]);
          end else if (fcnt == 3'(FOLD_STEPS)) begin
            if (fm[c] == FOLD_W'(SAMPLE_MAX)) fq[c] <= fq[c] + FQ_W'(1);
          end else begin
            lvl[c] <= lvl_pick[c];
          end
        end
      end
      ST_QV_WAIT: begin
        for (int c = 0; c < 3; c++) qv[c] <= quo[c][QV_W-1:0];
      end
      ST_OV_WAIT: begin
        for (int c = 0; c < 3; c++) ov[c] <= quo[c][15:0];
      end
      ST_ERR: begin
        for (int c = 0; c < 3; c++) begin
          err[c] <= sat_err(28'(xv[c]) - 28'(qv[c]));
        end
      end
      default: begin
        lum <= lum;
      end
    endcase
  end

  // ---- error state and position ----------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      for (int c = 0; c < 3; c++) begin
        carry[c] <= '0;
        pa[c]    <= '0;
        pb[c]    <= '0;
      end
    end else begin
      if (state == ST_WR1) begin
        for (int c = 0; c < 3; c++) begin
          carry[c] <= last_col ? '0 : share16(err[c], 3'd7);
          pa[c]    <= sat_err(28'(pb[c]) + 28'(share16(err[c], 3'd5)));
          pb[c]    <= share16(err[c], 3'd1);
        end
      end
      if (state == ST_WR2 && last_col) begin
        for (int c = 0; c < 3; c++) begin
          pa[c] <= '0;
          pb[c] <= '0;
        end
      end
      if (state == ST_OUT && out_free) begin
        if (last_col) begin
          column_count <= '0;
          row_count    <= (row_count >= h_last) ? 16'd0 : row_count + 16'd1;
        end else begin
          column_count <= col + 1'b1;
        end
      end
    end
  end

  // ---- output register -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      dst_valid <= 1'b1;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      dst_pixel.red_out      <= ov[0];
      dst_pixel.green_out    <= ov[1];
      dst_pixel.blue_out     <= ov[2];
      dst_pixel.end_of_frame <= last_col && (row_count >= h_last);
    end
  end

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    take |=> src_stall)
    else $error("second item taken while one is in work");

  a_out_from_out_state: assert property (@(posedge clk) disable iff (rst)
    $rose(dst_valid) |-> $past(state) == ST_OUT)
    else $error("result shown outside the output step");

  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_QV_GO |-> lvl[0] <= f_lvl && lvl[1] <= f_lvl && lvl[2] <= f_lvl)
    else $error("level above top code");

  a_write_in_line: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> mem_waddr <= w_last)
    else $error("line store write past row end");

  a_dividers_in_step: assert property (@(posedge clk) disable iff (rst)
    ddone[0] |-> ddone[1] && ddone[2])
    else $error("divider lanes out of step");
`endif

endmodule
